[rtl/core/dpf_pkg.sv]
// Shared types and constants for the dedup packet FIFO.
package dpf_pkg;

    localparam int SRC_W   = 16;
    localparam int DST_W   = 16;
    localparam int TS_W    = 32;
    localparam int ENTRY_W = SRC_W + DST_W + TS_W;
    localparam int CAP_W   = 9;
    localparam int MCNT_W  = 9;
    localparam int MODE_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD = 2'd0,
        MODE_FWD = 2'd1,
        MODE_CNT = 2'd2,
        MODE_NOP = 2'd3
    } t_mode;

    typedef struct packed {
        logic shift;   // take neighbor's entry
        logic load;    // write entry at selected position
    } t_cell_ctl;

endpackage

[rtl/core/dpf_cell.sv]
// One storage cell of the packet chain.
module dpf_cell #(
    parameter int AW  = 8,
    parameter int IDX = 0
) (
    input  logic                         i_clk,
    input  dpf_pkg::t_cell_ctl           i_ctl,
    input  logic [AW-1:0]                i_wp,
    input  logic [dpf_pkg::ENTRY_W-1:0]  i_wdata,
    input  logic [dpf_pkg::ENTRY_W-1:0]  i_nbr,
    output logic [dpf_pkg::ENTRY_W-1:0]  o_data
);
    import dpf_pkg::*;

    logic [ENTRY_W-1:0] r_entry;
    logic [ENTRY_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load && (i_wp == AW'(IDX))) begin
            n_entry = i_wdata;
        end else if (i_ctl.shift) begin
            n_entry = i_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_data = r_entry;

endmodule

[rtl/core/dpf_ctl.sv]
// Sequencer, head comparator and result register of the dedup packet FIFO.
module dpf_ctl #(
    parameter int DEPTH = 256,
    localparam int AW    = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dpf_pkg::MODE_W-1:0]    i_mode,
    input  logic [dpf_pkg::SRC_W-1:0]     i_source,
    input  logic [dpf_pkg::DST_W-1:0]     i_destination,
    input  logic [dpf_pkg::TS_W-1:0]      i_timestamp,
    input  logic [dpf_pkg::TS_W-1:0]      i_start_time,
    input  logic [dpf_pkg::TS_W-1:0]      i_end_time,
    input  logic                          i_cfg_we,
    input  logic [dpf_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic [dpf_pkg::ENTRY_W-1:0]   i_head,
    output dpf_pkg::t_cell_ctl            o_cell_ctl,
    output logic [AW-1:0]                 o_wp,
    output logic [dpf_pkg::ENTRY_W-1:0]   o_wdata,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_ok,
    output logic [dpf_pkg::SRC_W-1:0]     o_source,
    output logic [dpf_pkg::DST_W-1:0]     o_destination,
    output logic [dpf_pkg::TS_W-1:0]      o_timestamp,
    output logic [dpf_pkg::MCNT_W-1:0]    o_match_count
);
    import dpf_pkg::*;

    localparam int CW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic [CAP_W-1:0]    r_cap;
    logic                r_o_valid, n_o_valid;
    logic [AW-1:0]       r_k, n_k;
    logic                r_dup, n_dup;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    t_mode               r_mode, n_mode;
    logic [ENTRY_W-1:0]  r_key, n_key;
    logic [TS_W-1:0]     r_lo, n_lo;
    logic [TS_W-1:0]     r_hi, n_hi;
    logic                r_o_ok, n_o_ok;
    logic [SRC_W-1:0]    r_o_src, n_o_src;
    logic [DST_W-1:0]    r_o_dst, n_o_dst;
    logic [TS_W-1:0]     r_o_ts, n_o_ts;
    logic [MCNT_W-1:0]   r_o_cnt, n_o_cnt;

    logic                out_free;
    logic                accept;
    logic                hit;
    logic                dup_hit;
    logic                cnt_hit;
    logic [CW-1:0]       occ_ext;
    logic [CW-1:0]       lim;
    logic                evict;
    logic [CW-1:0]       cnt_ext;

    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;

    assign hit     = CNT_W'(r_k) < r_occ;
    assign dup_hit = hit && (i_head == r_key);
    assign cnt_hit = hit && (i_head[TS_W +: DST_W] == r_key[TS_W +: DST_W])
                     && (i_head[TS_W-1:0] >= r_lo) && (i_head[TS_W-1:0] <= r_hi);

    // effective limit: zero acts as one, clipped to the depth
    always_comb begin
        lim = CW'(r_cap);
        if (r_cap == '0) begin
            lim = CW'(1);
        end
        if (lim > CW'(DEPTH)) begin
            lim = CW'(DEPTH);
        end
    end

    assign occ_ext = CW'(r_occ);
    assign evict   = occ_ext >= lim;
    assign cnt_ext = CW'(r_cnt);

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_o_valid = r_o_valid;
        n_k       = r_k;
        n_dup     = r_dup;
        n_cnt     = r_cnt;
        n_mode    = r_mode;
        n_key     = r_key;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_o_ok    = r_o_ok;
        n_o_src   = r_o_src;
        n_o_dst   = r_o_dst;
        n_o_ts    = r_o_ts;
        n_o_cnt   = r_o_cnt;
        o_cell_ctl = '0;
        o_wp      = evict ? AW'(r_occ - CNT_W'(1)) : AW'(r_occ);

        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = t_mode'(i_mode);
                    n_key  = {i_source, i_destination, i_timestamp};
                    n_lo   = i_start_time;
                    n_hi   = i_end_time;
                    n_k    = '0;
                    n_dup  = 1'b0;
                    n_cnt  = '0;
                    n_o_ok  = 1'b0;
                    n_o_src = '0;
                    n_o_dst = '0;
                    n_o_ts  = '0;
                    n_o_cnt = '0;
                    unique case (t_mode'(i_mode)) inside
                        MODE_ADD, MODE_CNT: begin
                            n_state = S_SCAN;
                        end
                        MODE_FWD: begin
                            n_o_valid = 1'b1;
                            if (r_occ != '0) begin
                                n_o_ok  = 1'b1;
                                n_o_src = i_head[TS_W + DST_W +: SRC_W];
                                n_o_dst = i_head[TS_W +: DST_W];
                                n_o_ts  = i_head[TS_W-1:0];
                                n_occ   = r_occ - CNT_W'(1);
                                o_cell_ctl.shift = 1'b1;
                            end
                        end
                        default: begin
                            n_o_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // rotate the whole chain once past the head
                o_cell_ctl.shift = 1'b1;
                n_dup = r_dup || dup_hit;
                n_cnt = r_cnt + CNT_W'(cnt_hit);
                n_k   = r_k + AW'(1);
                if (r_k == AW'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state   = S_IDLE;
                    n_o_valid = 1'b1;
                    n_o_ok    = 1'b0;
                    n_o_src   = '0;
                    n_o_dst   = '0;
                    n_o_ts    = '0;
                    n_o_cnt   = '0;
                    if (r_mode == MODE_ADD) begin
                        if (!r_dup) begin
                            n_o_ok = 1'b1;
                            o_cell_ctl.load  = 1'b1;
                            o_cell_ctl.shift = evict;
                            if (!evict) begin
                                n_occ = r_occ + CNT_W'(1);
                            end
                        end
                    end else begin
                        n_o_cnt = cnt_ext[MCNT_W-1:0];
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_occ     <= '0;
            r_o_valid <= 1'b0;
            r_cap     <= CAP_W'(256);
        end else begin
            r_state   <= n_state;
            r_occ     <= n_occ;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k     <= n_k;
        r_dup   <= n_dup;
        r_cnt   <= n_cnt;
        r_mode  <= n_mode;
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_o_ok  <= n_o_ok;
        r_o_src <= n_o_src;
        r_o_dst <= n_o_dst;
        r_o_ts  <= n_o_ts;
        r_o_cnt <= n_o_cnt;
    end

    assign o_wdata       = r_key;
    assign o_valid       = r_o_valid;
    assign o_ok          = r_o_ok;
    assign o_source      = r_o_src;
    assign o_destination = r_o_dst;
    assign o_timestamp   = r_o_ts;
    assign o_match_count = r_o_cnt;

endmodule

[rtl/core/dedup_packet_fifo_with_range_count.sv]
// Top level of the dedup packet FIFO with range count.
//
//  port group    dir  tdata (low bit first)                          tuser
//  s_axis_*      in   source, destination, timestamp, start, end     mode
//  m_axis_*      out  out_source, out_destination, out_timestamp,    ok
//                     match_count, zero pad
//  i_cfg_wr_*    in   capacity_limit, written whenever i_cfg_wr_en is high
//
// Forward and unused mode: the result is registered from the item and appears in the next cycle.
// Add and count: the cell chain rotates once past the head comparator, then, once the result
// register is free, the add is committed and the result registered.
// Reset clears occupancy and sets the limit to 256; cell contents are not cleared.
// A new item is taken when idle and the result register is empty or being read.
module dedup_packet_fifo_with_range_count #(
    parameter int DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // source, destination, timestamp, start, end
    input  logic [1:0]    s_axis_tuser,   // mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [79:0]   m_axis_tdata,   // out_source, out_destination, out_timestamp,
                                          // match_count, pad
    output logic          m_axis_tuser,   // ok
    input  logic          i_cfg_wr_en,
    input  logic [8:0]    i_cfg_wr_data
);
    import dpf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_cell_ctl          cell_ctl;
    logic [AW-1:0]      wp;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] cell_data [DEPTH];

    logic               ok;
    logic [SRC_W-1:0]   o_src;
    logic [DST_W-1:0]   o_dst;
    logic [TS_W-1:0]    o_ts;
    logic [MCNT_W-1:0]  o_cnt;

    dpf_ctl #(
        .DEPTH (DEPTH)
    ) u_ctl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_mode        (s_axis_tuser),
        .i_source      (s_axis_tdata[15:0]),
        .i_destination (s_axis_tdata[31:16]),
        .i_timestamp   (s_axis_tdata[63:32]),
        .i_start_time  (s_axis_tdata[95:64]),
        .i_end_time    (s_axis_tdata[127:96]),
        .i_cfg_we      (i_cfg_wr_en),
        .i_cfg_wdata   (i_cfg_wr_data),
        .i_head        (cell_data[0]),
        .o_cell_ctl    (cell_ctl),
        .o_wp          (wp),
        .o_wdata       (wdata),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_ok          (ok),
        .o_source      (o_src),
        .o_destination (o_dst),
        .o_timestamp   (o_ts),
        .o_match_count (o_cnt)
    );

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        localparam int NBR = (i + 1) % DEPTH;
        dpf_cell #(
            .AW  (AW),
            .IDX (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_wp    (wp),
            .i_wdata (wdata),
            .i_nbr   (cell_data[NBR]),
            .o_data  (cell_data[i])
        );
    end

    assign m_axis_tdata = {7'd0, o_cnt, o_ts, o_dst, o_src};
    assign m_axis_tuser = ok;

endmodule

[tb/dpf_checker.sv]
`timescale 1ns / 1ps
// Checker for the dedup packet FIFO: keeps its own store, predicts and compares each result.
module dpf_checker #(
    parameter int DEPTH = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  logic [127:0]  i_req_data,   // source, destination, timestamp, start, end
    input  logic [1:0]    i_req_user,   // mode
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  logic [79:0]   i_rsp_data,   // out_source, out_destination, out_timestamp,
                                        // match_count, pad
    input  logic          i_rsp_user,   // ok
    input  logic          i_cfg_wr_en,
    input  logic [8:0]    i_cfg_wr_data,
    output int            o_fail_count,
    output int            o_outstanding
);
    import dpf_pkg::*;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [DST_W-1:0] dst;
        logic [TS_W-1:0]  ts;
    } t_pkt;

    typedef struct packed {
        logic              ok;
        logic [SRC_W-1:0]  src;
        logic [DST_W-1:0]  dst;
        logic [TS_W-1:0]   ts;
        logic [MCNT_W-1:0] mcnt;
    } t_rsp;

    t_pkt             held_q[$];
    t_rsp             rsp_due_q[$];
    logic [CAP_W-1:0] cap_limit;
    int               n_fail = 0;
    int               n_rsp = 0;

    assign o_fail_count = n_fail;

    function automatic int eff_limit();
        int lim;
        lim = int'(cap_limit);
        if (lim == 0) lim = 1;
        if (lim > DEPTH) lim = DEPTH;
        return lim;
    endfunction

    task automatic apply_request(input t_mode m, input t_pkt p, input logic [TS_W-1:0] lo,
                                 input logic [TS_W-1:0] hi, output t_rsp r);
        bit   dup;
        int   n;
        t_pkt head;
        r = '0;
        dup = 1'b0;
        n = 0;
        case (m)
            MODE_ADD: begin
                foreach (held_q[k]) if (held_q[k] == p) dup = 1'b1;
                if (!dup) begin
                    if (held_q.size() >= eff_limit()) held_q.delete(0);
                    if (held_q.size() >= DEPTH) held_q.delete(0);
                    held_q.insert(held_q.size(), p);
                    r.ok = 1'b1;
                end
            end
            MODE_FWD: begin
                if (held_q.size() != 0) begin
                    head = held_q[0];
                    held_q.delete(0);
                    r.ok = 1'b1;
                    r.src = head.src;
                    r.dst = head.dst;
                    r.ts = head.ts;
                end
            end
            MODE_CNT: begin
                foreach (held_q[k])
                    if (held_q[k].dst == p.dst && held_q[k].ts >= lo && held_q[k].ts <= hi) n++;
                r.mcnt = n[MCNT_W-1:0];
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got_v,
                                   input logic [63:0] exp_v);
        $display("%0t: result %0d %s: got %0h, expected %0h", $time, n_rsp, field, got_v,
                 exp_v);
        n_fail++;
    endtask

    always @(posedge i_clk) begin : watch
        t_pkt req;
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            held_q.delete();
            rsp_due_q.delete();
            cap_limit = 9'd256;
        end else begin
            if (i_cfg_wr_en) cap_limit = i_cfg_wr_data;
            if (i_req_valid && i_req_ready) begin
                req.src = i_req_data[15:0];
                req.dst = i_req_data[31:16];
                req.ts = i_req_data[63:32];
                apply_request(t_mode'(i_req_user), req, i_req_data[95:64], i_req_data[127:96],
                              want);
                rsp_due_q.insert(rsp_due_q.size(), want);
            end
            if (i_rsp_valid && i_rsp_ready) begin
                got.ok = i_rsp_user;
                got.src = i_rsp_data[15:0];
                got.dst = i_rsp_data[31:16];
                got.ts = i_rsp_data[63:32];
                got.mcnt = i_rsp_data[72:64];
                if (rsp_due_q.size() == 0) begin
                    report_mismatch("unexpected item", 64'(got), 64'd0);
                end else begin
                    want = rsp_due_q[0];
                    rsp_due_q.delete(0);
                    if (got.ok !== want.ok)
                        report_mismatch("ok", 64'(got.ok), 64'(want.ok));
                    if (got.src !== want.src)
                        report_mismatch("out_source", 64'(got.src), 64'(want.src));
                    if (got.dst !== want.dst)
                        report_mismatch("out_destination", 64'(got.dst), 64'(want.dst));
                    if (got.ts !== want.ts)
                        report_mismatch("out_timestamp", 64'(got.ts), 64'(want.ts));
                    if (got.mcnt !== want.mcnt)
                        report_mismatch("match_count", 64'(got.mcnt), 64'(want.mcnt));
                end
                n_rsp++;
            end
        end
        o_outstanding <= rsp_due_q.size();
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the dedup packet FIFO: clock, reset, stimulus and verdict.
module tb_top;
    import dpf_pkg::*;

    localparam int FIFO_DEPTH  = 256;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [DST_W-1:0] dst;
        logic [TS_W-1:0]  ts;
    } t_pkt;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;   // source, destination, timestamp, start, end
    logic [1:0]    s_axis_tuser;   // mode
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [79:0]   m_axis_tdata;   // out_source, out_destination, out_timestamp, match_count, pad
    logic          m_axis_tuser;   // ok
    logic          i_cfg_wr_en;
    logic [8:0]    i_cfg_wr_data;

    int   fail_count;
    int   outstanding;
    int   cycle_cnt = 0;
    int   rx_stall_left = 0;
    bit   rx_quiet = 1'b0;
    bit   tx_burst = 1'b0;
    t_pkt sent_q[$];

    dedup_packet_fifo_with_range_count #(
        .DEPTH(FIFO_DEPTH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    dpf_checker #(
        .DEPTH(FIFO_DEPTH)
    ) u_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata),
        .i_req_user(s_axis_tuser),
        .i_rsp_valid(m_axis_tvalid),
        .i_rsp_ready(m_axis_tready),
        .i_rsp_data(m_axis_tdata),
        .i_rsp_user(m_axis_tuser),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .o_fail_count(fail_count),
        .o_outstanding(outstanding)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        if (rx_stall_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_quiet && $urandom_range(0, 7) == 0)
                rx_stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                            : $urandom_range(10, 40);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_id(input bit wide);
        int r;
        r = $urandom_range(0, 9);
        if (wide || r >= 7) return 16'($urandom);
        if (r < 2) return 16'h0000;
        if (r < 3) return 16'hffff;
        return 16'($urandom_range(1, 3));
    endfunction

    function automatic logic [31:0] pick_stamp(input bit wide);
        int r;
        r = $urandom_range(0, 9);
        if (wide || r >= 7) return $urandom;
        if (r < 1) return 32'h0;
        if (r < 2) return 32'hffffffff;
        return $urandom_range(0, 20);
    endfunction

    task automatic send_item(input t_mode m, input logic [15:0] src, input logic [15:0] dst,
                             input logic [31:0] ts, input logic [31:0] lo,
                             input logic [31:0] hi);
        int   gap;
        gap = tx_burst ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {hi, lo, ts, dst, src};
        s_axis_tuser <= m;
        do @(posedge i_clk); while (!s_axis_tready);
        if (m == MODE_ADD) begin
            sent_q.insert(sent_q.size(), t_pkt'({src, dst, ts}));
            if (sent_q.size() > 32) sent_q.delete(0);
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [8:0] lim);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= lim;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_item(input int add_w, input int fwd_w, input int cnt_w, input bit wide);
        int   r;
        int   c;
        t_pkt p;
        logic [31:0] lo;
        logic [31:0] hi;
        r = $urandom_range(0, 99);
        if (r < add_w) begin
            if (sent_q.size() != 0 && $urandom_range(0, wide ? 31 : 3) == 0) begin
                p = sent_q[$urandom_range(0, sent_q.size() - 1)];
            end else begin
                p.src = pick_id(wide);
                p.dst = pick_id(wide);
                p.ts = pick_stamp(wide);
            end
            send_item(MODE_ADD, p.src, p.dst, p.ts, $urandom, $urandom);
        end else if (r < add_w + fwd_w) begin
            send_item(MODE_FWD, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
        end else if (r < add_w + fwd_w + cnt_w) begin
            if (sent_q.size() != 0 && $urandom_range(0, 1) == 0)
                p = sent_q[$urandom_range(0, sent_q.size() - 1)];
            else
                p = {16'h0, pick_id(wide), pick_stamp(wide)};
            c = $urandom_range(0, 4);
            case (c)
                0: begin
                    lo = 32'h0;
                    hi = 32'hffffffff;
                end
                1: begin
                    lo = p.ts;
                    hi = p.ts;
                end
                2: begin
                    lo = $urandom_range(0, 10);
                    hi = lo + $urandom_range(0, 10);
                end
                3: begin
                    hi = $urandom_range(0, 1000);
                    lo = hi + $urandom_range(1, 1000);
                end
                default: begin
                    lo = $urandom;
                    hi = $urandom;
                end
            endcase
            send_item(MODE_CNT, 16'($urandom), p.dst, $urandom, lo, hi);
        end else begin
            send_item(MODE_NOP, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    task automatic run_phase(input logic [8:0] lim, input int n_items, input int add_w,
                             input int fwd_w, input int cnt_w, input bit wide);
        write_limit(lim);
        tx_burst = ($urandom_range(0, 3) == 0);
        repeat (n_items) begin
            if ($urandom_range(0, 49) == 0) drain_results();
            if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
            if ($urandom_range(0, 19) == 0) rx_quiet = !rx_quiet;
            random_item(add_w, fwd_w, cnt_w, wide);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = MODE_ADD;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store, then extremes, duplicates and range edges at the reset limit
        send_item(MODE_FWD, 0, 0, 0, 0, 0);
        send_item(MODE_CNT, 0, 0, 0, 0, 32'hffffffff);
        send_item(MODE_NOP, 16'hffff, 16'hffff, '1, '1, '1);
        send_item(MODE_ADD, 0, 0, 0, '1, '1);
        send_item(MODE_ADD, 16'hffff, 16'hffff, 32'hffffffff, 0, 0);
        send_item(MODE_ADD, 16'hffff, 16'hffff, 32'hffffffff, 0, 0);
        send_item(MODE_ADD, 16'h0001, 0, 32'hffffffff, 0, 0);
        send_item(MODE_ADD, 0, 0, 0, 0, 0);
        send_item(MODE_CNT, 16'hffff, 0, '1, 0, 32'hffffffff);
        send_item(MODE_CNT, 0, 0, 0, 32'hffffffff, 32'hffffffff);
        send_item(MODE_CNT, 0, 0, 0, 5, 4);
        send_item(MODE_CNT, 0, 16'hffff, 0, 32'hffffffff, 32'hffffffff);
        send_item(MODE_CNT, 0, 0, 0, 1, 32'hfffffffe);
        send_item(MODE_FWD, 0, 0, 0, 0, 0);
        send_item(MODE_ADD, 0, 0, 0, 0, 0);
        send_item(MODE_FWD, 0, 0, 0, 0, 0);
        send_item(MODE_FWD, 0, 0, 0, 0, 0);
        send_item(MODE_FWD, 0, 0, 0, 0, 0);
        send_item(MODE_FWD, 0, 0, 0, 0, 0);

        // limit zero behaves as one
        write_limit(9'd0);
        send_item(MODE_ADD, 16'd5, 16'd6, 32'd7, 0, 0);
        send_item(MODE_ADD, 16'd8, 16'd9, 32'd10, 0, 0);
        send_item(MODE_CNT, 0, 16'd9, 0, 0, 32'hffffffff);
        send_item(MODE_FWD, 0, 0, 0, 0, 0);
        send_item(MODE_FWD, 0, 0, 0, 0, 0);

        run_phase(9'd0, 40, 50, 20, 25, 1'b0);
        run_phase(9'd1, 40, 50, 20, 25, 1'b0);
        run_phase(9'($urandom_range(2, 16)), 50, 55, 15, 25, 1'b0);
        run_phase(9'd256, 40, 50, 20, 25, 1'b0);
        // limit above depth: fill the whole store and keep adding
        run_phase(9'd511, 290, 97, 0, 3, 1'b1);
        // limit far below occupancy
        run_phase(9'd3, 60, 35, 45, 15, 1'b0);

        drain_results();
        repeat (FIFO_DEPTH + 16) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
